@@ rtl/core/ess_pkg.sv @@
// ----------------------------------------------------------------------------
// ess_pkg
// Shared widths, codes and types of the engine start / stall controller.
// ----------------------------------------------------------------------------
`default_nettype none

package ess_pkg;

	// field widths
	localparam int REQ_W      = 2;
	localparam int SPD_W      = 16;
	localparam int RATIO_W    = 12;
	localparam int RATIO_FRAC = 8;
	localparam int MODE_W     = 2;
	localparam int TMO_W      = 8;
	localparam int ST_W       = 3;
	localparam int CD_W       = 15;
	localparam int STALL_W    = 8;

	// ratio (zero-extended) times a signed speed
	localparam int PROD_W     = RATIO_W + 1 + SPD_W;

	// stream and config port widths
	localparam int S_TDATA_W  = 40;
	localparam int S_TUSER_W  = REQ_W;
	localparam int M_TDATA_W  = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 12;

	// parameter defaults
	localparam int TICKS_PER_SECOND_DEF = 100;
	localparam int STALL_LIMIT_DEF      = 50;

	// detection thresholds
	localparam int DEV_LIMIT  = 500;
	localparam int SPEED_MIN  = 200;
	localparam int TRUNC_BIAS = (2 ** RATIO_FRAC) - 1;

	// request kinds
	localparam logic [REQ_W-1:0] REQ_TICK  = 2'd0;
	localparam logic [REQ_W-1:0] REQ_START = 2'd1;
	localparam logic [REQ_W-1:0] REQ_STOP  = 2'd2;

	// detection modes
	localparam logic [MODE_W-1:0] DET_PIN   = 2'd0;
	localparam logic [MODE_W-1:0] DET_SPEED = 2'd1;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_DETECT_MODE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CRANK_TMO   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_GEAR_RATIO  = 2'd2;

	// register reset values
	localparam logic [MODE_W-1:0]  DETECT_MODE_RST = 2'd0;
	localparam logic [TMO_W-1:0]   CRANK_TMO_RST   = 8'd10;
	localparam logic [RATIO_W-1:0] GEAR_RATIO_RST  = 12'd666;

	// load strobes for the detector stages
	typedef struct packed {
		logic load_s2;
		logic load_s3;
	} pipe_ctl_t;

endpackage

`default_nettype wire

@@ rtl/core/ess_cfg.sv @@
// ----------------------------------------------------------------------------
// ess_cfg
// Configuration register file: detect mode, crank timeout, gear ratio.
// ----------------------------------------------------------------------------
`default_nettype none

module ess_cfg (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               wr_en,
	input  wire logic [ess_pkg::CFG_IDX_W-1:0]      wr_index,
	input  wire logic [ess_pkg::CFG_DATA_W-1:0]     wr_data,
	output logic      [ess_pkg::MODE_W-1:0]         detect_mode,
	output logic      [ess_pkg::TMO_W-1:0]          crank_timeout_s,
	output logic      [ess_pkg::RATIO_W-1:0]        gear_ratio_q8
);

	logic [ess_pkg::MODE_W-1:0]  detect_mode_q;
	logic [ess_pkg::TMO_W-1:0]   crank_tmo_q;
	logic [ess_pkg::RATIO_W-1:0] gear_ratio_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			detect_mode_q <= ess_pkg::DETECT_MODE_RST;
			crank_tmo_q   <= ess_pkg::CRANK_TMO_RST;
			gear_ratio_q  <= ess_pkg::GEAR_RATIO_RST;
		end else if (wr_en) begin
			case (wr_index)
				ess_pkg::CFG_DETECT_MODE: detect_mode_q <= wr_data[ess_pkg::MODE_W-1:0];
				ess_pkg::CFG_CRANK_TMO:   crank_tmo_q   <= wr_data[ess_pkg::TMO_W-1:0];
				ess_pkg::CFG_GEAR_RATIO:  gear_ratio_q  <= wr_data[ess_pkg::RATIO_W-1:0];
				default: ;
			endcase
		end
	end

	assign detect_mode     = detect_mode_q;
	assign crank_timeout_s = crank_tmo_q;
	assign gear_ratio_q8   = gear_ratio_q;

endmodule

`default_nettype wire

@@ rtl/core/ess_detect.sv @@
// ----------------------------------------------------------------------------
// ess_detect
// Running detection: pin level, or speed deviation of motor one from
// minus ratio times motor two. Product registered, then compare.
// ----------------------------------------------------------------------------
`default_nettype none

module ess_detect (
	input  wire logic                                  clk,
	input  wire ess_pkg::pipe_ctl_t                    ctl,
	input  wire logic        [ess_pkg::MODE_W-1:0]     detect_mode,
	input  wire logic        [ess_pkg::RATIO_W-1:0]    gear_ratio_q8,
	input  wire logic signed [ess_pkg::SPD_W-1:0]      mg1_s1,
	input  wire logic signed [ess_pkg::SPD_W-1:0]      mg2_s1,
	input  wire logic                                  pin_s1,
	output logic                                       det_s3
);

	localparam int PW = ess_pkg::PROD_W;
	localparam int SW = ess_pkg::SPD_W;

	localparam logic signed [PW-1:0] EXP_MAX = PW'((2 ** (SW - 1)) - 1);
	localparam logic signed [PW-1:0] EXP_MIN = -PW'(2 ** (SW - 1));
	localparam logic signed [SW:0]   DEV_HI  = (SW + 1)'(ess_pkg::DEV_LIMIT);
	localparam logic signed [SW-1:0] SPD_HI  = SW'(ess_pkg::SPEED_MIN);

	logic signed [PW-1:0] ratio_sx;
	logic signed [PW-1:0] mg2_sx;
	logic signed [PW-1:0] prod_c;

	logic signed [PW-1:0] prod_s2;
	logic signed [SW-1:0] mg1_s2;
	logic                 fast_s2;
	logic                 pin_s2;

	logic signed [PW-1:0] prod_adj;
	logic signed [PW-1:0] quot;
	logic signed [PW-1:0] neg_quot;
	logic signed [SW-1:0] expected;
	logic signed [SW:0]   dev;
	logic                 speed_run;
	logic                 det_c;

	// stage 2: product and the motor-two magnitude check
	always_comb begin
		ratio_sx = {{(PW - ess_pkg::RATIO_W){1'b0}}, gear_ratio_q8};
		mg2_sx   = {{(PW - SW){mg2_s1[SW-1]}}, mg2_s1};
		prod_c   = ratio_sx * mg2_sx;
	end

	always_ff @(posedge clk) begin
		if (ctl.load_s2) begin
			prod_s2 <= prod_c;
			mg1_s2  <= mg1_s1;
			fast_s2 <= (mg2_s1 > SPD_HI) || (mg2_s1 < -SPD_HI);
			pin_s2  <= pin_s1;
		end
	end

	// stage 3: divide by 256 toward zero, negate, saturate, deviation
	always_comb begin
		prod_adj = prod_s2 + (prod_s2[PW-1] ? PW'(ess_pkg::TRUNC_BIAS) : PW'(0));
		quot     = prod_adj >>> ess_pkg::RATIO_FRAC;
		neg_quot = -quot;
		if (neg_quot > EXP_MAX)
			expected = EXP_MAX[SW-1:0];
		else if (neg_quot < EXP_MIN)
			expected = EXP_MIN[SW-1:0];
		else
			expected = neg_quot[SW-1:0];
		dev       = {mg1_s2[SW-1], mg1_s2} - {expected[SW-1], expected};
		speed_run = ((dev > DEV_HI) || (dev < -DEV_HI)) && fast_s2;
		case (detect_mode)
			ess_pkg::DET_PIN:   det_c = pin_s2;
			ess_pkg::DET_SPEED: det_c = speed_run;
			default:            det_c = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctl.load_s3) begin
			det_s3 <= det_c;
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/ess_fsm.sv @@
// ----------------------------------------------------------------------------
// ess_fsm
// Start / stall state machine with crank countdown and stall debounce.
// Result fields are registered here when an item is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module ess_fsm #(
	parameter int TICKS_PER_SECOND = ess_pkg::TICKS_PER_SECOND_DEF,
	parameter int STALL_LIMIT      = ess_pkg::STALL_LIMIT_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              fire,
	input  wire logic [ess_pkg::REQ_W-1:0]         req,
	input  wire logic                              det,
	input  wire logic [ess_pkg::TMO_W-1:0]         crank_timeout_s,
	output logic      [ess_pkg::ST_W-1:0]          published_status,
	output logic      [ess_pkg::ST_W-1:0]          new_state,
	output logic                                   start_out,
	output logic                                   engine_detected
);

	localparam int CW = ess_pkg::CD_W;
	localparam int KW = ess_pkg::STALL_W;

	typedef enum logic [ess_pkg::ST_W-1:0] {
		ST_OFF   = 3'd0,
		ST_CRANK = 3'd1,
		ST_RUN   = 3'd2,
		ST_STALL = 3'd3,
		ST_ERROR = 3'd4
	} state_t;

	state_t        state_q, state_d;
	logic [CW-1:0] crank_cd_q, crank_cd_d;
	logic [KW-1:0] stall_cnt_q, stall_cnt_d;
	logic          want_q, want_d;
	logic          starter_q, starter_d;
	logic          det_d;
	logic [CW-1:0] crank_load;
	logic [KW-1:0] stall_inc;

	always_comb begin
		crank_load = CW'({{(CW - ess_pkg::TMO_W){1'b0}}, crank_timeout_s} * CW'(TICKS_PER_SECOND));
		stall_inc  = (stall_cnt_q == {KW{1'b1}}) ? stall_cnt_q : stall_cnt_q + KW'(1);

		state_d     = state_q;
		crank_cd_d  = crank_cd_q;
		stall_cnt_d = stall_cnt_q;
		want_d      = want_q;
		starter_d   = starter_q;
		det_d       = 1'b0;

		case (req)
			ess_pkg::REQ_START: begin
				if (state_q == ST_OFF || state_q == ST_ERROR) begin
					want_d     = 1'b1;
					state_d    = ST_CRANK;
					crank_cd_d = crank_load;
					starter_d  = 1'b1;
				end
			end
			ess_pkg::REQ_STOP: begin
				want_d    = 1'b0;
				starter_d = 1'b0;
				if (state_q == ST_RUN || state_q == ST_CRANK)
					state_d = ST_OFF;
			end
			ess_pkg::REQ_TICK: begin
				det_d = det;
				case (state_q)
					ST_OFF: stall_cnt_d = '0;
					ST_CRANK: begin
						if (det) begin
							state_d    = ST_RUN;
							crank_cd_d = '0;
						end else if (crank_cd_q != '0) begin
							crank_cd_d = crank_cd_q - CW'(1);
						end else begin
							starter_d = 1'b0;
							state_d   = ST_ERROR;
						end
					end
					ST_RUN: begin
						if (!want_q) begin
							starter_d = 1'b0;
							state_d   = ST_OFF;
						end else if (!det) begin
							stall_cnt_d = stall_inc;
							// limit checked against the updated count
							if (stall_inc > KW'(STALL_LIMIT))
								state_d = ST_STALL;
						end else begin
							stall_cnt_d = '0;
						end
					end
					ST_STALL: begin
						starter_d = 1'b0;
						want_d    = 1'b0;
						state_d   = ST_ERROR;
					end
					default: starter_d = 1'b0;
				endcase
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= ST_OFF;
			crank_cd_q       <= '0;
			stall_cnt_q      <= '0;
			want_q           <= 1'b0;
			starter_q        <= 1'b0;
			published_status <= '0;
			new_state        <= '0;
			start_out        <= 1'b0;
			engine_detected  <= 1'b0;
		end else if (fire) begin
			state_q          <= state_d;
			crank_cd_q       <= crank_cd_d;
			stall_cnt_q      <= stall_cnt_d;
			want_q           <= want_d;
			starter_q        <= starter_d;
			published_status <= state_q;
			new_state        <= state_d;
			start_out        <= starter_d;
			engine_detected  <= det_d;
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/engine_start_stall_controller.sv @@
// ----------------------------------------------------------------------------
// engine_start_stall_controller
// Supervises an engine start: start/stop requests and 10 ms ticks drive a
// five-state controller with crank timeout and stall debounce.
// ----------------------------------------------------------------------------
//  channel  direction  signals                        item
//  s_       in         s_tvalid s_tready s_tdata s_tuser  request or tick
//  m_       out        m_tvalid m_tready m_tdata      one result per item
//  cfg_     in         cfg_valid cfg_ready cfg_index cfg_data  register write
//
//  One item per cycle sustained unless m_tready stalls; an item passes the
//  input reg, product reg, detect reg, then result reg, which drives m_tvalid.
//  ess_fsm updates its state per taken item, so items may follow back to back.
//  Reset clears state and valids and loads the register defaults.
//  m_tready low stalls the result register; bubbles ahead still fill.
// ----------------------------------------------------------------------------
`default_nettype none

module engine_start_stall_controller #(
	parameter int TICKS_PER_SECOND = ess_pkg::TICKS_PER_SECOND_DEF,
	parameter int STALL_LIMIT      = ess_pkg::STALL_LIMIT_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	// [15:0] mg1_speed, [31:16] mg2_speed, [32] run_pin, [39:33] zero
	input  wire logic [ess_pkg::S_TDATA_W-1:0]     s_tdata,
	// [1:0] req_type
	input  wire logic [ess_pkg::S_TUSER_W-1:0]     s_tuser,
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	// [2:0] published_status, [5:3] new_state, [6] start_out, [7] engine_detected
	output logic      [ess_pkg::M_TDATA_W-1:0]     m_tdata,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [ess_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [ess_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam int SW = ess_pkg::SPD_W;

	logic [ess_pkg::MODE_W-1:0]  detect_mode;
	logic [ess_pkg::TMO_W-1:0]   crank_timeout_s;
	logic [ess_pkg::RATIO_W-1:0] gear_ratio_q8;

	logic                          v_s1, v_s2, v_s3, out_v_q;
	logic [ess_pkg::REQ_W-1:0]     req_s1, req_s2, req_s3;
	logic signed [SW-1:0]          mg1_s1, mg2_s1;
	logic                          pin_s1;
	logic                          det_s3;

	logic                          out_rdy, rdy3, rdy2, rdy1;
	logic                          adv1, adv2, adv3, accept;
	ess_pkg::pipe_ctl_t            ctl;

	logic [ess_pkg::ST_W-1:0]      published_status, new_state;
	logic                          start_out, engine_detected;

	assign cfg_ready = 1'b1;

	ess_cfg u_cfg (
		.clk             (clk),
		.arst_n          (arst_n),
		.wr_en           (cfg_valid),
		.wr_index        (cfg_index),
		.wr_data         (cfg_data),
		.detect_mode     (detect_mode),
		.crank_timeout_s (crank_timeout_s),
		.gear_ratio_q8   (gear_ratio_q8)
	);

	// per-stage ready so bubbles close up under output backpressure
	always_comb begin
		out_rdy     = !out_v_q || m_tready;
		rdy3        = !v_s3 || out_rdy;
		rdy2        = !v_s2 || rdy3;
		rdy1        = !v_s1 || rdy2;
		adv3        = v_s3 && out_rdy;
		adv2        = v_s2 && rdy3;
		adv1        = v_s1 && rdy2;
		accept      = s_tvalid && rdy1;
		ctl.load_s2 = adv1;
		ctl.load_s3 = adv2;
	end

	assign s_tready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (accept)
				v_s1 <= 1'b1;
			else if (adv1)
				v_s1 <= 1'b0;
			if (adv1)
				v_s2 <= 1'b1;
			else if (adv2)
				v_s2 <= 1'b0;
			if (adv2)
				v_s3 <= 1'b1;
			else if (adv3)
				v_s3 <= 1'b0;
			if (adv3)
				out_v_q <= 1'b1;
			else if (m_tready)
				out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= s_tuser[ess_pkg::REQ_W-1:0];
			mg1_s1 <= s_tdata[SW-1:0];
			mg2_s1 <= s_tdata[2*SW-1:SW];
			pin_s1 <= s_tdata[2*SW];
		end
		if (adv1)
			req_s2 <= req_s1;
		if (adv2)
			req_s3 <= req_s2;
	end

	ess_detect u_detect (
		.clk           (clk),
		.ctl           (ctl),
		.detect_mode   (detect_mode),
		.gear_ratio_q8 (gear_ratio_q8),
		.mg1_s1        (mg1_s1),
		.mg2_s1        (mg2_s1),
		.pin_s1        (pin_s1),
		.det_s3        (det_s3)
	);

	ess_fsm #(
		.TICKS_PER_SECOND (TICKS_PER_SECOND),
		.STALL_LIMIT      (STALL_LIMIT)
	) u_fsm (
		.clk              (clk),
		.arst_n           (arst_n),
		.fire             (adv3),
		.req              (req_s3),
		.det              (det_s3),
		.crank_timeout_s  (crank_timeout_s),
		.published_status (published_status),
		.new_state        (new_state),
		.start_out        (start_out),
		.engine_detected  (engine_detected)
	);

	assign m_tvalid = out_v_q;
	assign m_tdata  = {engine_detected, start_out, new_state, published_status};

endmodule

`default_nettype wire
